>>> sv/exponential_easing_curve_assert.svh
// assertion macros shared by the easing curve modules
`ifndef EXPONENTIAL_EASING_CURVE_ASSERT_SVH
`define EXPONENTIAL_EASING_CURVE_ASSERT_SVH

// property that holds at every edge outside reset
`define EEC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that holds on the edge after a reset edge
`define EEC_ASSERT_AFTER_RESET(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (expr)) else $error(msg);

`endif

>>> sv/eec_pkg.sv
// shared types, constants and table functions for the exponential easing curve
package eec_pkg;

  localparam int TIME_BITS_DEF       = 16;
  localparam int FRAC_BITS_DEF       = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 64;

  localparam int DUR_MAX_BITS  = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int MODE_BITS     = 2;
  localparam int OUT_BITS      = 17;
  localparam int OUT_FRAC      = 16;
  localparam int WORK_BITS     = 30;
  localparam int DIV_STEPS     = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EASE_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION  = 1'b1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_IN     = 2'd0,
    MODE_OUT    = 2'd1,
    MODE_IN_OUT = 2'd2
  } ease_mode_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic force_en;
    logic force_one;
    logic halve;
    logic invert;
  } ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-f / 2^30) rounded to fbits fraction bits
  function automatic logic [63:0] exp_entry(input logic [63:0] f, input int fbits);
    logic [63:0] root [WORK_BITS+1];
    logic [63:0] y;
    root[0] = 64'd1 << (WORK_BITS - 1);
    for (int i = 1; i <= WORK_BITS; i++) begin
      root[i] = isqrt64(root[i-1] << WORK_BITS);
    end
    y = 64'd1 << WORK_BITS;
    for (int i = 1; i <= WORK_BITS; i++) begin
      if (f[WORK_BITS-i]) begin
        y = (y * root[i] + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
      end
    end
    y = (y + (64'd1 << (WORK_BITS - fbits - 1))) >> (WORK_BITS - fbits);
    return y;
  endfunction

endpackage

>>> sv/eec_divider.sv
// pipelined restoring divider, a few quotient bits per stage
module eec_divider #(
  parameter int DIV_BITS  = eec_pkg::DUR_MAX_BITS,
  parameter int NUM_BITS  = eec_pkg::DUR_MAX_BITS + 4,
  parameter int FRAC_BITS = eec_pkg::FRAC_BITS_DEF,
  parameter int QUOT_BITS = eec_pkg::FRAC_BITS_DEF + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_BITS-1:0]  in_num,
  input  eec_pkg::ctl_t        in_ctl,
  input  logic [DIV_BITS-1:0]  divisor,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [QUOT_BITS-1:0] out_quot,
  output eec_pkg::ctl_t        out_ctl
);

  localparam int SPS = eec_pkg::DIV_STEPS;
  localparam int NDS = QUOT_BITS / SPS;
  localparam int DVW = NUM_BITS + FRAC_BITS;

  logic [NDS-1:0]       v_r;
  logic [DIV_BITS-1:0]  rem_r [NDS];
  logic [QUOT_BITS-1:0] dvd_r [NDS];
  logic [QUOT_BITS-1:0] quot_r [NDS];
  eec_pkg::ctl_t        ctl_r [NDS];
  logic [NDS:0]         rdy;
  logic [DVW-1:0]       dvd_full;

  assign dvd_full = {in_num, {FRAC_BITS{1'b0}}};
  assign rdy[NDS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NDS; s++) begin : g_stage
    logic                 pv;
    logic [DIV_BITS-1:0]  prem;
    logic [QUOT_BITS-1:0] pdvd;
    logic [QUOT_BITS-1:0] pquot;
    eec_pkg::ctl_t        pctl;
    logic [DIV_BITS:0]    rs;
    logic [DIV_BITS-1:0]  rem_nxt;
    logic [QUOT_BITS-1:0] dvd_nxt;
    logic [QUOT_BITS-1:0] quot_nxt;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = DIV_BITS'(in_num >> (QUOT_BITS - FRAC_BITS));
      assign pdvd  = dvd_full[QUOT_BITS-1:0];
      assign pquot = '0;
      assign pctl  = in_ctl;
    end else begin : g_next
      assign pv    = v_r[s-1];
      assign prem  = rem_r[s-1];
      assign pdvd  = dvd_r[s-1];
      assign pquot = quot_r[s-1];
      assign pctl  = ctl_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_comb begin
      rem_nxt  = prem;
      dvd_nxt  = pdvd;
      quot_nxt = pquot;
      rs       = '0;
      for (int j = 0; j < SPS; j++) begin
        rs       = {rem_nxt, dvd_nxt[QUOT_BITS-1]};
        dvd_nxt  = dvd_nxt << 1;
        quot_nxt = quot_nxt << 1;
        if (rs >= {1'b0, divisor}) begin
          rs          = rs - {1'b0, divisor};
          quot_nxt[0] = 1'b1;
        end
        rem_nxt = rs[DIV_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= pv;
      end
      if (rdy[s] && pv) begin
        rem_r[s]  <= rem_nxt;
        dvd_r[s]  <= dvd_nxt;
        quot_r[s] <= quot_nxt;
        ctl_r[s]  <= pctl;
      end
    end
  end

  assign out_valid = v_r[NDS-1];
  assign out_quot  = quot_r[NDS-1];
  assign out_ctl   = ctl_r[NDS-1];

`include "exponential_easing_curve_assert.svh"

  `EEC_ASSERT_AFTER_RESET(a_div_reset_empty, clk, rst_n, v_r == '0, "divider not empty after reset")
  `EEC_ASSERT_ALWAYS(a_div_empty_ready, clk, rst_n, out_valid || in_ready, "empty divider stalls")
  `EEC_ASSERT_ALWAYS(a_div_ready_chain, clk, rst_n, !out_ready || in_ready, "ready lost in chain")

endmodule

>>> sv/exponential_easing_curve.sv
// exponential easing curve: elapsed time to eased fraction in Q1.16
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_elapsed_time
//  out_    | output    | out_valid / out_stall| out_tween_fraction
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// one item per cycle while out_stall is low; the divider stages form the exponent
// 10*num/duration, 4 quotient bits each
// reset clears the stage valid bits and sets ease_mode 0, duration all ones; no clearing pass
// each stage loads whenever it is empty or the stage after it moves, so a stalled
// output only stops the stages that are full behind it
module exponential_easing_curve #(
  parameter int TIME_BITS       = eec_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS       = eec_pkg::FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = eec_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [TIME_BITS-1:0]               in_elapsed_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [eec_pkg::OUT_BITS-1:0]       out_tween_fraction,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [eec_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [eec_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int DUR_BITS = (TIME_BITS < eec_pkg::DUR_MAX_BITS) ? TIME_BITS
                                                               : eec_pkg::DUR_MAX_BITS;
  localparam int MUL_BITS = DUR_BITS + 4;
  localparam int QW       = FRAC_BITS + 4;
  localparam int NDS      = (QW + eec_pkg::DIV_STEPS - 1) / eec_pkg::DIV_STEPS;
  localparam int QP       = NDS * eec_pkg::DIV_STEPS;
  localparam int IPW      = QP - FRAC_BITS;
  localparam int IW       = $clog2(EXP_TABLE_DEPTH);
  localparam int ENT_BITS = FRAC_BITS + 1;
  localparam int PRW      = FRAC_BITS + IW + 1;
  localparam logic [ENT_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [eec_pkg::MODE_BITS-1:0] ease_mode_r;
  logic [DUR_BITS-1:0]           duration_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ease_mode_r <= eec_pkg::MODE_IN;
      duration_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eec_pkg::CFG_EASE_MODE: ease_mode_r <= cfg_wdata[eec_pkg::MODE_BITS-1:0];
        eec_pkg::CFG_DURATION:  duration_r  <= DUR_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // handshake chain
  logic rdy_f;
  logic rdy_l;
  logic rdy_o;
  logic div_in_ready;

  // front stage: saturate, pick numerator and flags, times ten
  logic                f_v_r;
  logic [MUL_BITS-1:0] f_mul_r;
  eec_pkg::ctl_t       f_ctl_r;
  logic [DUR_BITS-1:0] d_eff;
  logic [DUR_BITS-1:0] t_sat;
  logic [DUR_BITS:0]   t2;
  logic [DUR_BITS:0]   d1;
  logic [DUR_BITS-1:0] num;
  logic [MUL_BITS-1:0] mul_nxt;
  eec_pkg::ctl_t       ctl_nxt;

  assign d_eff = (duration_r == '0) ? DUR_BITS'(1) : duration_r;
  assign t_sat = (in_elapsed_time > TIME_BITS'(d_eff)) ? d_eff : DUR_BITS'(in_elapsed_time);
  assign t2    = {t_sat, 1'b0};
  assign d1    = {1'b0, d_eff};

  always_comb begin
    num     = '0;
    ctl_nxt = '0;
    case (ease_mode_r)
      eec_pkg::MODE_IN: begin
        if (t_sat == '0) begin
          ctl_nxt.force_en = 1'b1;
        end else begin
          num = d_eff - t_sat;
        end
      end
      eec_pkg::MODE_OUT: begin
        if (t_sat == d_eff) begin
          ctl_nxt.force_en  = 1'b1;
          ctl_nxt.force_one = 1'b1;
        end else begin
          num            = t_sat;
          ctl_nxt.invert = 1'b1;
        end
      end
      eec_pkg::MODE_IN_OUT: begin
        if (t_sat == '0) begin
          ctl_nxt.force_en = 1'b1;
        end else if (t_sat == d_eff) begin
          ctl_nxt.force_en  = 1'b1;
          ctl_nxt.force_one = 1'b1;
        end else if (t2 < d1) begin
          num           = DUR_BITS'(d1 - t2);
          ctl_nxt.halve = 1'b1;
        end else begin
          num            = DUR_BITS'(t2 - d1);
          ctl_nxt.halve  = 1'b1;
          ctl_nxt.invert = 1'b1;
        end
      end
      default: begin
        ctl_nxt.force_en = 1'b1;
      end
    endcase
    mul_nxt = (MUL_BITS'(num) << 3) + (MUL_BITS'(num) << 1);
  end

  assign rdy_f    = !f_v_r || div_in_ready;
  assign in_stall = !rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (rdy_f) begin
      f_v_r <= in_valid;
    end
    if (rdy_f && in_valid) begin
      f_mul_r <= mul_nxt;
      f_ctl_r <= ctl_nxt;
    end
  end

  // exponent magnitude 10*num/d in Q.FRAC_BITS
  logic          div_out_valid;
  logic [QP-1:0] div_quot;
  eec_pkg::ctl_t div_ctl;

  eec_divider #(
    .DIV_BITS  (DUR_BITS),
    .NUM_BITS  (MUL_BITS),
    .FRAC_BITS (FRAC_BITS),
    .QUOT_BITS (QP)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r),
    .in_ready  (div_in_ready),
    .in_num    (f_mul_r),
    .in_ctl    (f_ctl_r),
    .divisor   (d_eff),
    .out_valid (div_out_valid),
    .out_ready (rdy_l),
    .out_quot  (div_quot),
    .out_ctl   (div_ctl)
  );

  // fraction table 2^(-k/depth)
  logic [ENT_BITS-1:0] exp_tab [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] FK = (64'(k) << eec_pkg::WORK_BITS) / EXP_TABLE_DEPTH;
    assign exp_tab[k] = ENT_BITS'(eec_pkg::exp_entry(FK, FRAC_BITS));
  end

  // lookup stage
  logic                l_v_r;
  logic [ENT_BITS-1:0] l_ent_r;
  logic [IPW-1:0]      l_ip_r;
  eec_pkg::ctl_t       l_ctl_r;
  logic [PRW-1:0]      idx_prod;
  logic [IW-1:0]       idx_raw;
  logic [IW-1:0]       idx;

  assign idx_prod = PRW'(div_quot[FRAC_BITS-1:0]) * PRW'(EXP_TABLE_DEPTH);
  assign idx_raw  = idx_prod[FRAC_BITS+IW-1:FRAC_BITS];
  assign idx      = (idx_raw > IW'(EXP_TABLE_DEPTH - 1)) ? IW'(EXP_TABLE_DEPTH - 1) : idx_raw;
  assign rdy_l    = !l_v_r || rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
    end else if (rdy_l) begin
      l_v_r <= div_out_valid;
    end
    if (rdy_l && div_out_valid) begin
      l_ent_r <= exp_tab[idx];
      l_ip_r  <= div_quot[QP-1:FRAC_BITS];
      l_ctl_r <= div_ctl;
    end
  end

  // shift, halve, mirror and output scaling
  logic [7:0]                   ip8;
  logic [ENT_BITS-1:0]          pw;
  logic [eec_pkg::OUT_BITS-1:0] frac_w;
  logic                         out_valid_r;
  logic [eec_pkg::OUT_BITS-1:0] out_frac_r;

  always_comb begin
    ip8 = 8'(l_ip_r);
    pw  = (ip8 >= 8'd32) ? '0 : (l_ent_r >> ip8);
    if (l_ctl_r.halve) begin
      pw = pw >> 1;
    end
    if (l_ctl_r.invert) begin
      pw = ONE_Q - pw;
    end
    if (l_ctl_r.force_en) begin
      pw = l_ctl_r.force_one ? ONE_Q : '0;
    end
  end

  if (FRAC_BITS > eec_pkg::OUT_FRAC) begin : g_round
    localparam logic [ENT_BITS-1:0] RND =
      ENT_BITS'(1) << (FRAC_BITS - eec_pkg::OUT_FRAC - 1);
    assign frac_w = eec_pkg::OUT_BITS'((pw + RND) >> (FRAC_BITS - eec_pkg::OUT_FRAC));
  end else if (FRAC_BITS == eec_pkg::OUT_FRAC) begin : g_same
    assign frac_w = eec_pkg::OUT_BITS'(pw);
  end else begin : g_widen
    assign frac_w = eec_pkg::OUT_BITS'(pw) << (eec_pkg::OUT_FRAC - FRAC_BITS);
  end

  assign rdy_o = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= l_v_r;
    end
    if (rdy_o && l_v_r) begin
      out_frac_r <= frac_w;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tween_fraction = out_frac_r;

`include "exponential_easing_curve_assert.svh"

  `EEC_ASSERT_AFTER_RESET(a_out_reset_empty, clk, rst_n, !out_valid, "item out after reset")
  `EEC_ASSERT_ALWAYS(a_frac_le_one, clk, rst_n, !out_valid || (out_tween_fraction <= 17'h10000), "fraction above one")
  `EEC_ASSERT_ALWAYS(a_empty_no_stall, clk, rst_n, out_valid || !in_stall, "input stalled with empty output")

endmodule
